/* hdl/ktk_pkg.sv */
// ktk_pkg: types, constants and helpers shared by the traction kernel blocks
// no dependencies
package ktk_pkg;

  localparam int LANES     = 9;
  localparam int DIV_STEPS = 64;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  localparam logic [36:0] EIGHT_PI_Q32 = 37'd107944301636;
  localparam logic [15:0] NU_RESET     = 16'd19661;
  localparam logic        REG_POISSON  = 1'b0;

  typedef struct packed {
    logic [35:0]       cos_v;
    logic [8:0][35:0]  a;
    logic [8:0][34:0]  w;
    logic [63:0]       rr;
  } ktk_mid_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } ktk_flags_t;

  // round half up, drop 30 fraction bits
  function automatic logic signed [34:0] rs30(input logic signed [64:0] x);
    logic signed [64:0] t;
    t = x + 65'sd536870912;
    return t[64:30];
  endfunction

  // (1 - 2 nu) in Q.30
  function automatic logic signed [32:0] c3_of(input logic [15:0] nu);
    logic signed [18:0] b;
    b = 19'sd65536 - $signed({2'b00, nu, 1'b0});
    return {b, 14'b0};
  endfunction

endpackage

/* hdl/ktk_if.sv */
// ktk_if: valid/ready channels for input items and result items
// no dependencies
interface ktk_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  logic [31:0]        distance;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  modport source(output valid, dir_x, dir_y, dir_z, distance, normal_x, normal_y, normal_z,
                 input ready);
  modport sink(input valid, dir_x, dir_y, dir_z, distance, normal_x, normal_y, normal_z,
               output ready);
endinterface

interface ktk_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] k_xx;
  logic signed [63:0] k_xy;
  logic signed [63:0] k_xz;
  logic signed [63:0] k_yx;
  logic signed [63:0] k_yy;
  logic signed [63:0] k_yz;
  logic signed [63:0] k_zx;
  logic signed [63:0] k_zy;
  logic signed [63:0] k_zz;
  modport source(output valid, k_xx, k_xy, k_xz, k_yx, k_yy, k_yz, k_zx, k_zy, k_zz,
                 input ready);
  modport sink(input valid, k_xx, k_xy, k_xz, k_yx, k_yy, k_yz, k_zx, k_zy, k_zz,
               output ready);
endinterface

/* hdl/ktk_front.sv */
// ktk_front: accepts items, normalizes to Q2.30, forms products and numerator terms
// depends on ktk_pkg and ktk_in_if
module ktk_front #(
  parameter int DIR_FRAC_BITS = 30
) (
  input  logic              clk,
  input  logic              rst_n,
  ktk_in_if.sink            in_ch,
  input  logic [15:0]       nu,
  output ktk_pkg::ktk_mid_t mid_data,
  output logic              mid_valid,
  input  logic              mid_full
);
  import ktk_pkg::*;

  localparam int SHR = (DIR_FRAC_BITS > 30) ? DIR_FRAC_BITS - 30 : 1;
  localparam int RND = (DIR_FRAC_BITS > 30) ? DIR_FRAC_BITS - 31 : 0;
  localparam int SHL = (DIR_FRAC_BITS < 30) ? 30 - DIR_FRAC_BITS : 0;

  function automatic logic signed [31:0] to_q30(input logic signed [31:0] v);
    logic signed [95:0] sx;
    logic signed [95:0] t;
    sx = 96'(v);
    if (DIR_FRAC_BITS > 30) begin
      t = (sx + (96'sd1 <<< RND)) >>> SHR;
    end else begin
      t = sx <<< SHL;
    end
    if (t > 96'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (t < -96'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return t[31:0];
    end
  endfunction

  logic               en;
  logic signed [31:0] din [3];
  logic signed [31:0] nin [3];

  logic               v1_r, v2_r, v3_r;
  logic signed [31:0] d1_r [3];
  logic signed [31:0] n1_r [3];
  logic [31:0]        r1_r;
  logic signed [63:0] dd2_r [3][3];
  logic signed [63:0] cr2_r [3][3];
  logic [31:0]        r2_r;
  ktk_mid_t           mid_r, mid_nxt;

  assign en          = !(v3_r && mid_full);
  assign in_ch.ready = en;
  assign mid_valid   = v3_r;
  assign mid_data    = mid_r;

  assign din[0] = in_ch.dir_x;
  assign din[1] = in_ch.dir_y;
  assign din[2] = in_ch.dir_z;
  assign nin[0] = in_ch.normal_x;
  assign nin[1] = in_ch.normal_y;
  assign nin[2] = in_ch.normal_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k] <= to_q30(din[k]);
        n1_r[k] <= to_q30(nin[k]);
      end
      r1_r <= in_ch.distance;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          dd2_r[i][j] <= d1_r[i] * d1_r[j];
          cr2_r[i][j] <= n1_r[j] * d1_r[i];
        end
      end
      r2_r  <= r1_r;
      mid_r <= mid_nxt;
    end
  end

  always_comb begin
    logic signed [35:0] cs;
    logic signed [34:0] q;
    logic signed [35:0] qx;
    logic signed [35:0] q3;
    logic signed [32:0] c3;
    c3 = c3_of(nu);
    cs = '0;
    for (int k = 0; k < 3; k++) begin
      cs = cs + 36'(rs30(65'(cr2_r[k][k])));
    end
    mid_nxt.cos_v = cs;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        q  = rs30(65'(dd2_r[i][j]));
        qx = 36'(q);
        q3 = qx + (qx <<< 1);
        if (i == j) begin
          mid_nxt.a[i*3+j] = q3 + 36'(c3);
          mid_nxt.w[i*3+j] = '0;
        end else begin
          mid_nxt.a[i*3+j] = q3;
          mid_nxt.w[i*3+j] = rs30(65'(cr2_r[i][j]) - 65'(cr2_r[j][i]));
        end
      end
    end
    mid_nxt.rr = 64'(r2_r) * 64'(r2_r);
  end

endmodule

/* hdl/ktk_queue.sv */
// ktk_queue: short item queue between the front and the back
// depends on ktk_pkg
module ktk_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  ktk_pkg::ktk_mid_t push_data,
  output logic              full,
  input  logic              pop,
  output ktk_pkg::ktk_mid_t head,
  output logic              empty
);
  import ktk_pkg::*;

  ktk_mid_t       mem [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign push  = push_valid && !full;
  assign head  = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

/* hdl/ktk_back.sv */
// ktk_back: numerator and denominator products, bit-per-stage division, rounding
// depends on ktk_pkg and ktk_out_if
module ktk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       nu,
  input  ktk_pkg::ktk_mid_t mid_data,
  input  logic              mid_empty,
  output logic              pop,
  ktk_out_if.source         out_ch
);
  import ktk_pkg::*;

  function automatic logic [180:0] div_step(input logic [116:0] rem, input logic [63:0] xq,
                                            input logic [116:0] den);
    logic [117:0] t;
    logic [117:0] dx;
    logic         ge;
    t  = {rem, xq[63]};
    dx = {1'b0, den};
    ge = (t >= dx);
    return {ge ? 117'(t - dx) : t[116:0], xq[62:0], ge};
  endfunction

  logic               en;
  logic [52:0]        kd_r;
  logic signed [32:0] c3;

  logic               vb1_r, vb2_r, vb3_r;
  logic signed [71:0] pa_r [LANES];
  logic signed [67:0] pc_r [LANES];
  logic [63:0]        pp_ll_r, pp_lh_r;
  logic [52:0]        pp_hl_r, pp_hh_r;
  logic signed [71:0] p_r [LANES];
  logic [116:0]       den2_r, den3_r;
  logic [71:0]        mag_r [LANES];
  logic               neg3_r [LANES];

  logic [DIV_STEPS:0] vs_r;
  logic [116:0]       rem_r [DIV_STEPS+1][LANES];
  logic [63:0]        xq_r [DIV_STEPS+1][LANES];
  ktk_flags_t         fl_r [DIV_STEPS+1][LANES];
  logic [116:0]       dn_r [DIV_STEPS+1];

  logic               out_valid_r;
  logic [63:0]        kout_r [LANES];
  logic [63:0]        kout_nxt [LANES];

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && !mid_empty;
  assign c3  = c3_of(nu);

  always_ff @(posedge clk) begin
    kd_r <= 53'(EIGHT_PI_Q32) * 53'(17'h10000 - {1'b0, nu});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb1_r       <= 1'b0;
      vb2_r       <= 1'b0;
      vb3_r       <= 1'b0;
      vs_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vb1_r       <= !mid_empty;
      vb2_r       <= vb1_r;
      vb3_r       <= vb2_r;
      vs_r        <= {vs_r[DIV_STEPS-1:0], vb3_r};
      out_valid_r <= vs_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        pa_r[l] <= $signed(mid_data.a[l]) * $signed(mid_data.cos_v);
        pc_r[l] <= c3 * $signed(mid_data.w[l]);
      end
      pp_ll_r <= 64'(kd_r[31:0]) * 64'(mid_data.rr[31:0]);
      pp_lh_r <= 64'(kd_r[31:0]) * 64'(mid_data.rr[63:32]);
      pp_hl_r <= 53'(kd_r[52:32]) * 53'(mid_data.rr[31:0]);
      pp_hh_r <= 53'(kd_r[52:32]) * 53'(mid_data.rr[63:32]);

      for (int l = 0; l < LANES; l++) begin
        p_r[l] <= pa_r[l] - 72'(pc_r[l]);
      end
      den2_r <= 117'(pp_ll_r) + (117'(pp_lh_r) << 32) + (117'(pp_hl_r) << 32)
              + (117'(pp_hh_r) << 64);

      for (int l = 0; l < LANES; l++) begin
        mag_r[l]  <= p_r[l][71] ? 72'(-p_r[l]) : 72'(p_r[l]);
        neg3_r[l] <= !p_r[l][71];
      end
      den3_r <= den2_r;

      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l]     <= 117'(mag_r[l][71:12]);
        xq_r[0][l]      <= {mag_r[l][11:0], 52'b0};
        fl_r[0][l].neg  <= neg3_r[l];
        fl_r[0][l].zero <= (mag_r[l] == '0);
        fl_r[0][l].ovf  <= (den3_r == '0) || (117'(mag_r[l][71:12]) >= den3_r);
      end
      dn_r[0] <= den3_r;

      for (int s = 0; s < DIV_STEPS; s++) begin
        for (int l = 0; l < LANES; l++) begin
          {rem_r[s+1][l], xq_r[s+1][l]} <= div_step(rem_r[s][l], xq_r[s][l], dn_r[s]);
          fl_r[s+1][l] <= fl_r[s][l];
        end
        dn_r[s+1] <= dn_r[s];
      end

      for (int l = 0; l < LANES; l++) begin
        kout_r[l] <= kout_nxt[l];
      end
    end
  end

  always_comb begin
    logic        rnd;
    logic [64:0] qr;
    logic [64:0] limit;
    logic [63:0] m;
    for (int l = 0; l < LANES; l++) begin
      rnd   = ({rem_r[DIV_STEPS][l], 1'b0} >= {1'b0, dn_r[DIV_STEPS]});
      qr    = {1'b0, xq_r[DIV_STEPS][l]} + 65'(rnd);
      limit = fl_r[DIV_STEPS][l].neg ? 65'h0_8000_0000_0000_0000 : 65'h0_7FFF_FFFF_FFFF_FFFF;
      if (fl_r[DIV_STEPS][l].ovf || (qr > limit)) begin
        m = limit[63:0];
      end else begin
        m = qr[63:0];
      end
      if (fl_r[DIV_STEPS][l].zero) begin
        kout_nxt[l] = '0;
      end else if (fl_r[DIV_STEPS][l].neg) begin
        kout_nxt[l] = 64'(-m);
      end else begin
        kout_nxt[l] = m;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.k_xx  = kout_r[0];
  assign out_ch.k_xy  = kout_r[1];
  assign out_ch.k_xz  = kout_r[2];
  assign out_ch.k_yx  = kout_r[3];
  assign out_ch.k_yy  = kout_r[4];
  assign out_ch.k_yz  = kout_r[5];
  assign out_ch.k_zx  = kout_r[6];
  assign out_ch.k_zy  = kout_r[7];
  assign out_ch.k_zz  = kout_r[8];

endmodule

/* hdl/kelvin_traction_kernel.sv */
// kelvin_traction_kernel: top level of the 3d elastic traction kernel
// depends on ktk_pkg, ktk_if, ktk_front, ktk_queue and ktk_back
//
// Usage:
//   in_ch carries one item per handshake: unit direction, distance r (Q16.16)
//   and unit surface normal; out_ch returns the nine traction kernel entries
//   (signed Q32.32, saturated, row-major) for each item, in order.
//   Poisson's ratio is written through the APB port at address 0 (Q0.16);
//   it may only change while no item is in flight.
//   From input accept to out_ch.valid an item passes three front stages,
//   one queue slot, three product/magnitude stages, a setup stage,
//   64 stages of the one-bit-per-stage divider and the output register.
//   Throughput is one item per cycle while out_ch.ready stays high; the
//   divider pipeline sets the latency. With out_ch.valid high and ready
//   low the back pipeline holds; the front keeps taking items until the
//   four-entry queue fills, then in_ch.ready drops. Synchronous reset empties
//   the pipeline and queue and sets Poisson's ratio to 19661 (about 0.3).
module kelvin_traction_kernel #(
  parameter int DIR_FRAC_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  ktk_in_if.sink      in_ch,
  ktk_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ktk_pkg::*;

  logic [15:0] nu_r;
  ktk_mid_t    fr_data;
  logic        fr_valid;
  ktk_mid_t    q_head;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POISSON) ? {16'b0, nu_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nu_r <= NU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_POISSON)) begin
      nu_r <= pwdata[15:0];
    end
  end

  ktk_front #(
    .DIR_FRAC_BITS(DIR_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .nu       (nu_r),
    .mid_data (fr_data),
    .mid_valid(fr_valid),
    .mid_full (q_full)
  );

  ktk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fr_valid),
    .push_data (fr_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  ktk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .nu       (nu_r),
    .mid_data (q_head),
    .mid_empty(q_empty),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

endmodule
